@@ rtl/core/crcfr_pkg.sv @@
package crcfr_pkg;

    localparam int COUNT_BITS = 17;
    localparam int CMP_W      = 18;
    localparam int ADDR_W     = 2;
    localparam int LEN_W      = 17;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SYNC_RESET   = 8'h55;
    localparam logic [7:0] TYPE_STATE59 = 8'hAE;
    localparam logic [7:0] TYPE_TRACK16 = 8'hAB;
    localparam logic [7:0] TYPE_TEXT    = 8'hAC;
    localparam logic [7:0] TYPE_CMD21   = 8'hAA;
    localparam logic [7:0] TYPE_ACK9    = 8'hAD;

    localparam logic [ADDR_W-1:0] REG_SYNC = '0;

    typedef enum logic [2:0] {
        KIND_STATE59 = 3'd0,
        KIND_TRACK16 = 3'd1,
        KIND_TEXT    = 3'd2,
        KIND_CMD21   = 3'd3,
        KIND_ACK9    = 3'd4,
        KIND_UNKNOWN = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_CRC_ERR   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind             frame_kind;
        t_status           status;
        logic [15:0]       computed_crc;
        logic [15:0]       rcvd_crc;
        logic [LEN_W-1:0]  frame_length;
    } t_out_item;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_kind kind_of(input logic [15:0] hw, input logic [7:0] sync);
        t_kind k;
        unique case (hw[7:0])
            TYPE_STATE59: k = KIND_STATE59;
            TYPE_TRACK16: k = KIND_TRACK16;
            TYPE_TEXT:    k = KIND_TEXT;
            TYPE_CMD21:   k = KIND_CMD21;
            TYPE_ACK9:    k = KIND_ACK9;
            default:      k = KIND_UNKNOWN;
        endcase
        if (hw[15:8] != sync) begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

@@ rtl/core/crcfr_regs.sv @@
module crcfr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crcfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [7:0]                  o_sync_byte
);
    import crcfr_pkg::*;

    logic [7:0]        r_sync;
    logic [ADDR_W-1:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr >> 2;
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (wr_en && reg_idx == REG_SYNC) begin
            r_sync <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC: prdata = {24'h000000, r_sync};
            default:  prdata = 32'h00000000;
        endcase
    end

    assign o_sync_byte = r_sync;

endmodule

@@ rtl/core/crcfr_engine.sv @@
module crcfr_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_sync_byte,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  crcfr_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output crcfr_pkg::t_out_item  o_out_item
);
    import crcfr_pkg::*;

    logic                  r_in_vld;
    t_in_item              r_in;
    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_crc;
    logic [15:0]           r_hdr;
    logic [15:0]           r_len;
    logic [15:0]           r_cap;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic [COUNT_BITS-1:0] n_count;
    logic [15:0]           n_crc;
    logic [15:0]           n_hdr;
    logic [15:0]           n_len;
    logic [15:0]           n_cap;

    logic                  out_free;
    logic                  fire;
    logic                  room;
    logic                  has_pos;
    logic [CMP_W-1:0]      idx_x;
    logic [CMP_W-1:0]      n_x;
    logic [CMP_W-1:0]      pos;
    logic [CMP_W-1:0]      need;
    t_kind                 kind_hdr;
    t_kind                 kind;
    t_status               status;
    logic [15:0]           comp;
    logic [15:0]           recv;
    t_out_item             res;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_vld && !fire;

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_cap   = r_cap;
        idx_x   = CMP_W'(r_count);
        room    = (r_count != COUNT_MAX);

        if (room) begin
            if (r_count == COUNT_BITS'(0)) begin
                n_hdr = {r_in.data_byte, 8'h00};
            end else if (r_count == COUNT_BITS'(1)) begin
                n_hdr = {r_hdr[15:8], r_in.data_byte};
            end else if (r_count == COUNT_BITS'(2)) begin
                n_len = {r_in.data_byte, 8'h00};
            end else if (r_count == COUNT_BITS'(3)) begin
                n_len = {r_len[15:8], r_in.data_byte};
            end
        end

        kind_hdr = kind_of(n_hdr, i_sync_byte);
        unique case (kind_hdr)
            KIND_STATE59: begin
                pos  = CMP_W'(56);
                need = CMP_W'(59);
            end
            KIND_TRACK16: begin
                pos  = CMP_W'(14);
                need = CMP_W'(16);
            end
            KIND_TEXT: begin
                pos  = CMP_W'(n_len) + CMP_W'(6);
                need = CMP_W'(n_len) + CMP_W'(8);
            end
            KIND_CMD21: begin
                pos  = CMP_W'(19);
                need = CMP_W'(21);
            end
            KIND_ACK9: begin
                pos  = CMP_W'(7);
                need = CMP_W'(9);
            end
            default: begin
                pos  = '1;
                need = CMP_W'(9);
            end
        endcase
        has_pos = (r_count >= COUNT_BITS'(2)) && (kind_hdr != KIND_UNKNOWN);

        if (room) begin
            if (!has_pos || idx_x < pos) begin
                n_crc = crc_feed(r_crc, r_in.data_byte);
            end else if (idx_x == pos) begin
                n_cap = {r_in.data_byte, r_cap[7:0]};
            end else if (idx_x == pos + CMP_W'(1)) begin
                n_cap = {r_cap[15:8], r_in.data_byte};
            end
            n_count = r_count + COUNT_BITS'(1);
        end

        n_x  = CMP_W'(n_count);
        kind = (n_count >= COUNT_BITS'(2)) ? kind_hdr : KIND_UNKNOWN;
        comp = (kind == KIND_UNKNOWN) ? 16'h0000 : n_crc;
        recv = (kind != KIND_UNKNOWN && n_x >= pos + CMP_W'(2)) ? n_cap : 16'h0000;

        if (n_count < COUNT_BITS'(4)) begin
            status = ST_SHORT;
        end else if (kind == KIND_UNKNOWN) begin
            status = ST_UNKNOWN;
        end else if (kind == KIND_TEXT && n_count < COUNT_BITS'(8)) begin
            status = ST_SHORT;
        end else if (n_x != need || n_count == COUNT_MAX) begin
            status = ST_BAD_LEN;
        end else if (comp != recv) begin
            status = ST_CRC_ERR;
        end else begin
            status = ST_OK;
        end

        res.frame_kind   = kind;
        res.status       = status;
        res.computed_crc = comp;
        res.rcvd_crc     = recv;
        res.frame_length = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_hdr     <= '0;
            r_len     <= '0;
            r_cap     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                if (r_in.last_byte) begin
                    r_count <= '0;
                    r_crc   <= CRC_INIT;
                    r_hdr   <= '0;
                    r_len   <= '0;
                    r_cap   <= '0;
                end else begin
                    r_count <= n_count;
                    r_crc   <= n_crc;
                    r_hdr   <= n_hdr;
                    r_len   <= n_len;
                    r_cap   <= n_cap;
                end
            end
            if (fire && r_in.last_byte) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (fire && r_in.last_byte) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/crc16_frame_receiver.sv @@
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+----------------------------
// in        | input     | i_in_valid / o_in_stall      | i_in_item  (data, last mark)
// out       | output    | o_out_valid / i_out_stall    | o_out_item (kind, status,
//           |           |                              |   CRCs, length)
// config    | input     | APB psel / penable / pready  | sync byte at address 0
//
// One item is taken per cycle unless a last item waits for the result register to free;
// a frame's last item passes the input register, then its result enters the result register.
// The input register feeds one pass of header decode, CRC byte step and length check
// into the result register, which sets the one-item-per-cycle figure.
// Reset is synchronous and clears the frame state and both valid flags.
// While a result waits under stall, items that are not last keep flowing; a last item
// holds in the input register until the result register is free.
module crc16_frame_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crcfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  crcfr_pkg::t_in_item          i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output crcfr_pkg::t_out_item         o_out_item
);
    import crcfr_pkg::*;

    logic [7:0] sync_byte;

    crcfr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_sync_byte (sync_byte)
    );

    crcfr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync_byte (sync_byte),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/core/crcfr_checker.sv @@
module crcfr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input crcfr_pkg::t_out_item o_out_item
);
    import crcfr_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid is set right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("A stalled result item changed or was dropped.");

    a_unknown_zero_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_kind == KIND_UNKNOWN |->
            o_out_item.computed_crc == 16'h0000 && o_out_item.rcvd_crc == 16'h0000)
        else $error("An unknown frame reports a nonzero CRC.");

    a_ok_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_OK |->
            o_out_item.computed_crc == o_out_item.rcvd_crc &&
            o_out_item.frame_kind != KIND_UNKNOWN)
        else $error("A good frame reports mismatched CRCs or an unknown kind.");

    a_tiny_is_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_length < LEN_W'(4) |->
            o_out_item.status == ST_SHORT)
        else $error("A frame under four bytes is not reported as short.");

endmodule

bind crc16_frame_receiver crcfr_checker u_crcfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ test/tb_crc16_frame_receiver.sv @@
`timescale 1ns / 100ps

module tb_crc16_frame_receiver;
    import crcfr_pkg::*;

    localparam int unsigned NO_OFFSET   = 32'hFFFF_FFFF;
    localparam int unsigned SAT_COUNT   = COUNT_MAX;
    localparam int          STALL_LIMIT = 5000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_item;

    logic [7:0]  sync_reg;
    int unsigned byte_cnt;
    logic [15:0] run_crc;
    logic [15:0] hdr_word;
    logic [15:0] len_word;
    logic [15:0] cap_crc;

    t_out_item   frame_results_q[$];
    t_out_item   expected_item;
    logic [7:0]  frame_bytes[$];

    bit quiet;
    int errors;
    int results_seen;
    int bytes_sent;
    int idle_cycles;

    crc16_frame_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic t_kind kind_from_header(input logic [15:0] hw);
        t_kind k;
        if (hw[15:8] != sync_reg) begin
            return KIND_UNKNOWN;
        end
        case (hw[7:0])
            TYPE_STATE59: k = KIND_STATE59;
            TYPE_TRACK16: k = KIND_TRACK16;
            TYPE_TEXT:    k = KIND_TEXT;
            TYPE_CMD21:   k = KIND_CMD21;
            TYPE_ACK9:    k = KIND_ACK9;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic int unsigned crc_offset(input t_kind k, input logic [15:0] lf);
        case (k)
            KIND_STATE59: return 56;
            KIND_TRACK16: return 14;
            KIND_TEXT:    return 32'd6 + lf;
            KIND_CMD21:   return 19;
            KIND_ACK9:    return 7;
            default:      return NO_OFFSET;
        endcase
    endfunction

    function automatic int unsigned frame_need_len(input t_kind k, input logic [15:0] lf);
        case (k)
            KIND_STATE59: return 59;
            KIND_TRACK16: return 16;
            KIND_TEXT:    return 32'd8 + lf;
            KIND_CMD21:   return 21;
            default:      return 9;
        endcase
    endfunction

    function automatic logic [7:0] type_code(input t_kind k);
        case (k)
            KIND_STATE59: return TYPE_STATE59;
            KIND_TRACK16: return TYPE_TRACK16;
            KIND_TEXT:    return TYPE_TEXT;
            KIND_CMD21:   return TYPE_CMD21;
            KIND_ACK9:    return TYPE_ACK9;
            default:      return 8'h00;
        endcase
    endfunction

    function automatic void clear_frame_state();
        byte_cnt = 0;
        run_crc  = CRC_INIT;
        hdr_word = 16'h0000;
        len_word = 16'h0000;
        cap_crc  = 16'h0000;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    // Advances the frame state by one accepted byte and queues the frame
    // report when the byte closes the datagram.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        int unsigned idx;
        int unsigned n;
        int unsigned pos;
        t_kind       k;
        t_status     st;
        logic [15:0] comp;
        logic [15:0] recv;
        t_out_item   r;
        idx = byte_cnt;
        if (idx < SAT_COUNT) begin
            case (idx)
                0:       hdr_word = {b, 8'h00};
                1:       hdr_word[7:0] = b;
                2:       len_word = {b, 8'h00};
                3:       len_word[7:0] = b;
                default: ;
            endcase
            pos = (idx < 2) ? NO_OFFSET : crc_offset(kind_from_header(hdr_word), len_word);
            if (idx < pos) begin
                run_crc = crc_step(run_crc, b);
            end else if (idx == pos) begin
                cap_crc[15:8] = b;
            end else if (idx == pos + 1) begin
                cap_crc[7:0] = b;
            end
            byte_cnt = idx + 1;
        end
        if (!last) begin
            return;
        end
        n    = byte_cnt;
        k    = (n >= 2) ? kind_from_header(hdr_word) : KIND_UNKNOWN;
        pos  = crc_offset(k, len_word);
        comp = run_crc;
        recv = (n >= pos + 2) ? cap_crc : 16'h0000;
        if (k == KIND_UNKNOWN) begin
            comp = 16'h0000;
            recv = 16'h0000;
        end
        if (n < 4) begin
            st = ST_SHORT;
        end else if (k == KIND_UNKNOWN) begin
            st = ST_UNKNOWN;
        end else if (k == KIND_TEXT && n < 8) begin
            st = ST_SHORT;
        end else if (n != frame_need_len(k, len_word) || n >= SAT_COUNT) begin
            st = ST_BAD_LEN;
        end else if (comp != recv) begin
            st = ST_CRC_ERR;
        end else begin
            st = ST_OK;
        end
        r.frame_kind   = k;
        r.status       = st;
        r.computed_crc = comp;
        r.rcvd_crc     = recv;
        r.frame_length = n[LEN_W-1:0];
        frame_results_q.insert(frame_results_q.size(), r);
        clear_frame_state();
    endfunction

    // Fills frame_bytes with a frame of the given kind under the current sync byte.
    function automatic void build_frame(input t_kind k, input logic [15:0] lf, input bit good);
        int unsigned n;
        int unsigned pos;
        logic [15:0] c;
        frame_bytes.delete();
        n = frame_need_len(k, lf);
        for (int unsigned i = 0; i < n; i++) begin
            add_byte(8'($urandom_range(0, 255)));
        end
        frame_bytes[0] = sync_reg;
        frame_bytes[1] = type_code(k);
        if (k == KIND_TEXT) begin
            frame_bytes[2] = lf[15:8];
            frame_bytes[3] = lf[7:0];
        end
        pos = crc_offset(k, lf);
        c   = CRC_INIT;
        for (int unsigned i = 0; i < pos; i++) begin
            c = crc_step(c, frame_bytes[i]);
        end
        if (!good) begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame_bytes[pos]     = c[15:8];
        frame_bytes[pos + 1] = c[7:0];
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (o_in_stall);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SYNC;
        pwdata  <= {24'h000000, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sync_reg = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_each_kind();
        for (int k = 0; k < 5; k++) begin
            build_frame(t_kind'(k), 16'd5, 1'b1);
            send_frame();
        end
        build_frame(KIND_TEXT, 16'd0, 1'b1);
        send_frame();
    endtask

    task automatic test_crc_mismatch();
        for (int k = 0; k < 5; k++) begin
            build_frame(t_kind'(k), 16'd3, 1'b0);
            send_frame();
        end
    endtask

    task automatic test_short_frames();
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{sync_reg, TYPE_ACK9};
        send_frame();
        frame_bytes = '{sync_reg, TYPE_TEXT, 8'h00};
        send_frame();
        frame_bytes = '{~sync_reg, TYPE_CMD21};
        send_frame();
        frame_bytes = '{sync_reg, TYPE_TEXT, 8'h00, 8'h00, 8'h01, 8'h02};
        send_frame();
    endtask

    task automatic test_unknown_header();
        build_frame(KIND_CMD21, 16'd0, 1'b1);
        frame_bytes[0] = ~sync_reg;
        send_frame();
        build_frame(KIND_ACK9, 16'd0, 1'b1);
        frame_bytes[1] = 8'h00;
        send_frame();
    endtask

    task automatic test_length_errors();
        build_frame(KIND_TRACK16, 16'd0, 1'b1);
        void'(frame_bytes.pop_back());
        send_frame();
        build_frame(KIND_TRACK16, 16'd0, 1'b1);
        add_byte(8'hA5);
        send_frame();
        build_frame(KIND_TEXT, 16'd4, 1'b1);
        repeat (2) void'(frame_bytes.pop_back());
        send_frame();
        build_frame(KIND_STATE59, 16'd0, 1'b1);
        void'(frame_bytes.pop_back());
        send_frame();
    endtask

    task automatic test_sync_register();
        logic [7:0] settings[4];
        logic [7:0] old_sync;
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom_range(1, 254));
        settings[3] = SYNC_RESET;
        for (int s = 0; s < 4; s++) begin
            old_sync = sync_reg;
            wait_drained();
            write_sync(settings[s]);
            build_frame(t_kind'(s + 1), 16'($urandom_range(0, 8)), 1'b1);
            send_frame();
            build_frame(KIND_CMD21, 16'd0, 1'b1);
            frame_bytes[0] = old_sync;
            send_frame();
        end
    endtask

    task automatic test_random_frames();
        int    frames;
        int    start_bytes;
        int    pick;
        int    cut;
        t_kind k;
        frames      = 0;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 130 || frames < 5) begin
            k    = t_kind'($urandom_range(0, 4));
            pick = $urandom_range(0, 99);
            build_frame(k, 16'($urandom_range(0, 24)), pick >= 10);
            if (pick < 72) begin
            end else if (pick < 78) begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                repeat (cut) void'(frame_bytes.pop_back());
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                frame_bytes[0] ^= 8'($urandom_range(1, 255));
            end else if (pick < 92) begin
                frame_bytes[1] = 8'($urandom_range(0, 255));
            end else if (pick < 96) begin
                frame_bytes[3] = 8'($urandom_range(0, 255));
            end else begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            end
            if (frames == 2) begin
                wait_drained();
            end
            send_frame();
            frames++;
        end
    endtask

    task automatic test_long_text();
        quiet = 1'b1;
        build_frame(KIND_TEXT, 16'd40, 1'b1);
        send_frame();
        quiet = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && !quiet) begin
            i_out_stall <= ($urandom_range(0, 99) < 24);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (frame_results_q.size() == 0) begin
                $error("unexpected result: frame_kind %0d status %0d",
                       o_out_item.frame_kind, o_out_item.status);
                errors++;
            end else begin
                expected_item = frame_results_q.pop_front();
                if (o_out_item.frame_kind !== expected_item.frame_kind) begin
                    $error("frame_kind expected %0d got %0d",
                           expected_item.frame_kind, o_out_item.frame_kind);
                    errors++;
                end
                if (o_out_item.status !== expected_item.status) begin
                    $error("status expected %0d got %0d",
                           expected_item.status, o_out_item.status);
                    errors++;
                end
                if (o_out_item.computed_crc !== expected_item.computed_crc) begin
                    $error("computed_crc expected %h got %h",
                           expected_item.computed_crc, o_out_item.computed_crc);
                    errors++;
                end
                if (o_out_item.rcvd_crc !== expected_item.rcvd_crc) begin
                    $error("rcvd_crc expected %h got %h",
                           expected_item.rcvd_crc, o_out_item.rcvd_crc);
                    errors++;
                end
                if (o_out_item.frame_length !== expected_item.frame_length) begin
                    $error("frame_length expected %0d got %0d",
                           expected_item.frame_length, o_out_item.frame_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = 32'h0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        sync_reg   = SYNC_RESET;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_each_kind();
        test_crc_mismatch();
        test_short_frames();
        test_unknown_header();
        test_length_errors();
        test_sync_register();
        test_random_frames();
        test_long_text();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_regs.sv
rtl/core/crcfr_engine.sv
rtl/core/crc16_frame_receiver.sv
rtl/core/crcfr_checker.sv
test/tb_crc16_frame_receiver.sv
